// File: src/jtd_pkg.sv
// jtd_pkg: shared types, constants and the per-joint deviation test
// for the joint trajectory decimator; no dependencies
`default_nettype none

package jtd_pkg;

    localparam int JOINT_COUNT = 6;
    localparam int JOINT_W     = 32;
    localparam int STAMP_W     = 48;
    localparam int TOL_W       = 31;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1049);

    // output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // window fill codes
    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_TWO  = 2'd2;

    typedef logic signed [JOINT_W-1:0] t_joint;
    typedef t_joint [JOINT_COUNT-1:0]  t_joint_vec;

    typedef struct packed {
        t_joint_vec         joints;
        logic [STAMP_W-1:0] stamp;
        logic               last;
    } t_point;

    // |a - b| of two signed joint values, exact in JOINT_W unsigned bits
    function automatic logic [JOINT_W-1:0] abs_diff(t_joint a, t_joint b);
        logic signed [JOINT_W:0] d;
        logic signed [JOINT_W:0] neg;
        d   = {a[JOINT_W-1], a} - {b[JOINT_W-1], b};
        neg = -d;
        return d[JOINT_W] ? neg[JOINT_W-1:0] : d[JOINT_W-1:0];
    endfunction

    // true when the path prev -> mid -> next bends by more than the tolerance
    function automatic logic joint_deviates(t_joint p, t_joint m, t_joint n,
                                            logic [TOL_W-1:0] tol);
        logic [JOINT_W+1:0] lhs;
        logic [JOINT_W+1:0] rhs;
        lhs = (JOINT_W+2)'(abs_diff(m, p)) + (JOINT_W+2)'(abs_diff(n, m));
        rhs = (JOINT_W+2)'(abs_diff(n, p)) + (JOINT_W+2)'(tol);
        return lhs > rhs;
    endfunction

endpackage

`default_nettype wire

// File: src/joint_trajectory_decimator.sv
// joint_trajectory_decimator: three-point window thinning of joint trajectories
// depends on jtd_pkg (types, constants, deviation test)
`default_nettype none

// Usage
//   input channel: i_in_valid / o_in_ready carry one trajectory point per
//   transfer (six joint positions, time stamp, last mark).
//   output channel: o_out_valid / i_out_ready carry the kept points in order.
//   config: i_cfg_wr_en writes the tolerance from i_cfg_wr_data; the user is
//   to write it only while the block is idle, which the block does not enforce.
// Flow: a point taken into the input register is judged as it leaves it, and
//   its results are written into the output queue, whose head is the output.
// Throughput: one point per cycle, but the input register holds when fewer
//   than two queue slots are free. A point that completes a trajectory after
//   a significant middle point yields two results, which drain through the
//   four-entry output queue at one per cycle while i_out_ready is high.
// Reset: synchronous, active low; empties the window, the input register and
//   the queue, and sets the tolerance to 1049 (about 0.001 rad).
// Stall: when the receiver holds i_out_ready low the queue fills, then the
//   input register stops, then o_in_ready drops; nothing is lost.
module joint_trajectory_decimator
    import jtd_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [TOL_W-1:0]          i_cfg_wr_data,
    // input channel
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic signed [JOINT_W-1:0] i_joint_0,
    input  wire logic signed [JOINT_W-1:0] i_joint_1,
    input  wire logic signed [JOINT_W-1:0] i_joint_2,
    input  wire logic signed [JOINT_W-1:0] i_joint_3,
    input  wire logic signed [JOINT_W-1:0] i_joint_4,
    input  wire logic signed [JOINT_W-1:0] i_joint_5,
    input  wire logic [STAMP_W-1:0]        i_stamp_ns,
    input  wire logic                      i_is_last,
    // output channel
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic signed [JOINT_W-1:0]      o_out_joint_0,
    output logic signed [JOINT_W-1:0]      o_out_joint_1,
    output logic signed [JOINT_W-1:0]      o_out_joint_2,
    output logic signed [JOINT_W-1:0]      o_out_joint_3,
    output logic signed [JOINT_W-1:0]      o_out_joint_4,
    output logic signed [JOINT_W-1:0]      o_out_joint_5,
    output logic [STAMP_W-1:0]             o_out_stamp_ns,
    output logic                           o_out_last
);

    // tolerance register
    logic [TOL_W-1:0] r_tol;

    // input register
    logic   r_s1_valid;
    t_point r_s1;
    t_point w_in;

    // window
    logic [1:0]         r_seen;
    logic [1:0]         n_seen;
    t_joint_vec         r_older_j;
    t_joint_vec         n_older_j;
    logic [STAMP_W-1:0] r_older_s;
    logic [STAMP_W-1:0] n_older_s;
    t_joint_vec         r_mid_j;
    t_joint_vec         n_mid_j;
    logic [STAMP_W-1:0] r_mid_s;
    logic [STAMP_W-1:0] n_mid_s;

    // output queue
    t_point                r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic [FIFO_CNT_W-1:0] n_count;

    logic   w_s1_fire;
    logic   w_in_xfer;
    logic   w_pop;
    logic   w_sig;
    logic   w_push_a;
    logic   w_push_b;
    t_point w_pt_a;
    t_point w_pt_b;
    t_point w_mid_pt;
    t_point w_head;

    assign w_in.joints[0] = i_joint_0;
    assign w_in.joints[1] = i_joint_1;
    assign w_in.joints[2] = i_joint_2;
    assign w_in.joints[3] = i_joint_3;
    assign w_in.joints[4] = i_joint_4;
    assign w_in.joints[5] = i_joint_5;
    assign w_in.stamp     = i_stamp_ns;
    assign w_in.last      = i_is_last;

    // the judged point only moves on when two queue slots are free
    assign w_s1_fire  = r_s1_valid && (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign o_in_ready = !r_s1_valid || w_s1_fire;
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_pop      = o_out_valid && i_out_ready;

    // middle point is kept if any joint bends beyond the tolerance
    always_comb begin
        w_sig = 1'b0;
        for (int j = 0; j < JOINT_COUNT; j++) begin
            if (joint_deviates(r_older_j[j], r_mid_j[j], r_s1.joints[j], r_tol)) begin
                w_sig = 1'b1;
            end
        end
    end

    assign w_mid_pt.joints = r_mid_j;
    assign w_mid_pt.stamp  = r_mid_s;
    assign w_mid_pt.last   = 1'b0;

    // window update and up to two results per point
    always_comb begin
        n_seen    = r_seen;
        n_older_j = r_older_j;
        n_older_s = r_older_s;
        n_mid_j   = r_mid_j;
        n_mid_s   = r_mid_s;
        w_push_a  = 1'b0;
        w_push_b  = 1'b0;
        w_pt_a    = r_s1;
        w_pt_b    = r_s1;
        if (w_s1_fire) begin
            unique case (r_seen)
                SEEN_NONE: begin
                    // first point always passes
                    w_push_a = 1'b1;
                    if (!r_s1.last) begin
                        n_older_j = r_s1.joints;
                        n_older_s = r_s1.stamp;
                        n_seen    = SEEN_ONE;
                    end
                end
                SEEN_ONE: begin
                    if (r_s1.last) begin
                        w_push_a = 1'b1;
                        n_seen   = SEEN_NONE;
                    end else begin
                        n_mid_j = r_s1.joints;
                        n_mid_s = r_s1.stamp;
                        n_seen  = SEEN_TWO;
                    end
                end
                default: begin
                    // full window (a count above two acts as two)
                    n_older_j = r_mid_j;
                    n_older_s = r_mid_s;
                    n_mid_j   = r_s1.joints;
                    n_mid_s   = r_s1.stamp;
                    n_seen    = r_s1.last ? SEEN_NONE : SEEN_TWO;
                    if (w_sig) begin
                        w_push_a = 1'b1;
                        w_pt_a   = w_mid_pt;
                        w_push_b = r_s1.last;
                    end else begin
                        w_push_a = r_s1.last;
                    end
                end
            endcase
        end
    end

    assign n_count = r_count + FIFO_CNT_W'(w_push_a) + FIFO_CNT_W'(w_push_b)
                     - FIFO_CNT_W'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol      <= TOL_RESET;
            r_s1_valid <= 1'b0;
            r_seen     <= SEEN_NONE;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tol <= i_cfg_wr_data;
            end
            if (w_in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            r_seen   <= n_seen;
            r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(w_push_a) + FIFO_PTR_W'(w_push_b);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1 <= w_in;
        end
        r_older_j <= n_older_j;
        r_older_s <= n_older_s;
        r_mid_j   <= n_mid_j;
        r_mid_s   <= n_mid_s;
        if (w_push_a) begin
            r_fifo[r_wr_ptr] <= w_pt_a;
        end
        if (w_push_b) begin
            r_fifo[r_wr_ptr + FIFO_PTR_W'(1)] <= w_pt_b;
        end
    end

    assign w_head         = r_fifo[r_rd_ptr];
    assign o_out_valid    = (r_count != '0);
    assign o_out_joint_0  = w_head.joints[0];
    assign o_out_joint_1  = w_head.joints[1];
    assign o_out_joint_2  = w_head.joints[2];
    assign o_out_joint_3  = w_head.joints[3];
    assign o_out_joint_4  = w_head.joints[4];
    assign o_out_joint_5  = w_head.joints[5];
    assign o_out_stamp_ns = w_head.stamp;
    assign o_out_last     = w_head.last;

endmodule

`default_nettype wire
